// ===== hw/rtl/sprite_list_tile_expander_pkg.sv =====
`timescale 1ns / 1ps
// shared constants and cell geometry helpers for the sprite tile expander
package slte_pkg;

    localparam int SPRITE_COUNT_DEF = 128;
    localparam int RAM_AW = 10;

    localparam logic [1:0] CMD_WRITE   = 2'd0;
    localparam logic [1:0] CMD_READ    = 2'd1;
    localparam logic [1:0] CMD_RENDER  = 2'd2;
    localparam logic [1:0] CMD_IGNORED = 2'd3;

    localparam logic [1:0] REG_X_OFFSET  = 2'd0;
    localparam logic [1:0] REG_Y_OFFSET  = 2'd1;
    localparam logic [1:0] REG_CODE_MASK = 2'd2;
    localparam logic [1:0] REG_FTB       = 2'd3;

    localparam logic [8:0] X_BIAS = 9'd104;

    function automatic logic [5:0] cell_x_add(input logic [2:0] i);
        logic [5:0] r;
        begin
            r = {1'b0, i[2], 1'b0, i[1], 1'b0, i[0]};
            return r;
        end
    endfunction

    function automatic logic [5:0] cell_y_add(input logic [2:0] i);
        logic [5:0] r;
        begin
            r = {i[2], 1'b0, i[1], 1'b0, i[0], 1'b0};
            return r;
        end
    endfunction

    function automatic logic [3:0] size_w(input logic [2:0] s);
        logic [3:0] r;
        begin
            case (s)
                3'd0: r = 4'd1;
                3'd1: r = 4'd2;
                3'd2: r = 4'd1;
                3'd3: r = 4'd2;
                3'd4: r = 4'd4;
                3'd5: r = 4'd2;
                3'd6: r = 4'd4;
                default: r = 4'd8;
            endcase
            return r;
        end
    endfunction

    function automatic logic [3:0] size_h(input logic [2:0] s);
        logic [3:0] r;
        begin
            case (s)
                3'd0: r = 4'd1;
                3'd1: r = 4'd1;
                3'd2: r = 4'd2;
                3'd3: r = 4'd2;
                3'd4: r = 4'd2;
                3'd5: r = 4'd4;
                3'd6: r = 4'd4;
                default: r = 4'd8;
            endcase
            return r;
        end
    endfunction

    // start of cell i: (512*(128-zoom)*i + 2048) >> 12 == ((128-zoom)*i + 4) >> 3
    function automatic logic [7:0] zoom_start(input logic [5:0] zoom, input logic [3:0] i);
        logic [7:0]  f;
        logic [11:0] p;
        begin
            f = 8'd128 - {2'b00, zoom};
            p = f * i + 12'd4;
            return p[10:3];
        end
    endfunction

endpackage

// ===== hw/rtl/slte_ram.sv =====
`timescale 1ns / 1ps
// sprite byte ram with clearing pass and registered read
module slte_ram #(
    parameter int AW = slte_pkg::RAM_AW
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata,
    output logic          clear_busy
);
    logic [7:0]  mem [2**AW];
    logic [AW:0] clr_reg;
    logic        busy_reg;

    assign clear_busy = busy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg  <= '0;
            busy_reg <= 1'b1;
        end else if (busy_reg) begin
            clr_reg <= clr_reg + 1'b1;
            if (clr_reg == (AW+1)'(2**AW - 1)) busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (busy_reg) mem[clr_reg[AW-1:0]] <= 8'd0;
        else if (we)  mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule

// ===== hw/rtl/sprite_list_tile_expander.sv =====
`timescale 1ns / 1ps
// sprite tile expander top level: command sequencer over the sprite ram
//
// channel   direction  contents
// s_axis    in         command, address, write_data, priority_slot
// m_axis    out        read_data, tile_code ... cell_height, last on tlast
// cfg       in         x_offset, y_offset, tile_code_mask, front_to_back
//
// render: a scan of every sprite through the single ram read port, then an
// entry fetch, then one cell per cycle while the output is taken. after reset
// a clearing pass zeroes the ram; no command is accepted meanwhile. m_axis
// stalls hold the cell.
module sprite_list_tile_expander #(
    parameter int SPRITE_COUNT = slte_pkg::SPRITE_COUNT_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // command[1:0], address[11:2], write_data[19:12], priority_slot[26:20]
    input  logic [31:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // read_data[7:0], tile_code[20:8], colour[28:21], shadow[29], pos_x[40:30],
    // pos_y[51:41], flip_x[52], flip_y[53], cell_width[58:54], cell_height[63:59]
    output logic [63:0] m_axis_tdata,
    output logic        m_axis_tlast,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [12:0] cfg_data
);
    localparam int SW = $clog2(SPRITE_COUNT);

    typedef enum logic [2:0] {ST_IDLE, ST_READ, ST_SCAN, ST_FETCH, ST_EMIT} state_t;

    state_t      state_reg;
    logic [8:0]  xoff_reg, yoff_reg;
    logic [12:0] mask_reg;
    logic        ftb_reg;
    logic [6:0]  slot_reg;
    logic [SW:0] scan_reg;      // sprite index issued
    logic [SW:0] chk_reg;       // sprite index whose byte is on rdata
    logic        chk_vld_reg;
    logic        found_reg;
    logic [SW-1:0] hit_reg;
    logic [3:0]  fcnt_reg;
    logic [7:0]  e_reg [8];
    logic [2:0]  cx_reg, cy_reg;
    logic        busy;
    logic [9:0]  raddr;
    logic [7:0]  rdata;
    logic        s_acc;
    logic [1:0]  cmd;
    logic [9:0]  addr;

    assign cmd   = s_axis_tdata[1:0];
    assign addr  = s_axis_tdata[11:2];
    assign s_axis_tready = (state_reg == ST_IDLE) && !busy && !m_axis_tvalid;
    assign s_acc = s_axis_tvalid && s_axis_tready;

    always_comb begin
        case (state_reg)
            ST_SCAN:  raddr = 10'({scan_reg[SW-1:0], 3'b000}) & 10'h3f8;
            ST_FETCH: raddr = 10'({hit_reg, fcnt_reg[2:0]});
            default:  raddr = addr;
        endcase
    end

    slte_ram u_ram (
        .aclk(aclk), .aresetn(aresetn),
        .we(s_acc && cmd == slte_pkg::CMD_WRITE), .waddr(addr),
        .wdata(s_axis_tdata[19:12]), .raddr(raddr), .rdata(rdata), .clear_busy(busy)
    );

    // sprite decode
    logic [2:0]  size;
    logic [3:0]  w, h;
    logic [12:0] code;
    logic        fx, fy;
    logic [5:0]  zx, zy;
    logic [2:0]  ix, iy;
    logic [7:0]  sx0, sx1, sy0, sy1;
    logic [12:0] c;
    logic [8:0]  xw;
    logic [10:0] px, py;
    always_comb begin
        size = e_reg[1][7:5];
        w = slte_pkg::size_w(size);
        h = slte_pkg::size_h(size);
        code = {e_reg[1][4:0], e_reg[2]};
        if (w >= 4'd2) code[0] = 1'b0;
        if (h >= 4'd2) code[1] = 1'b0;
        if (w >= 4'd4) code[2] = 1'b0;
        if (h >= 4'd4) code[3] = 1'b0;
        if (w >= 4'd8) code[4] = 1'b0;
        if (h >= 4'd8) code[5] = 1'b0;
        fx = e_reg[6][1];
        fy = e_reg[4][1];
        zx = e_reg[6][7:2];
        zy = e_reg[4][7:2];
        ix = fx ? 3'(w - 4'd1 - {1'b0, cx_reg}) : cx_reg;
        iy = fy ? 3'(h - 4'd1 - {1'b0, cy_reg}) : cy_reg;
        sx0 = slte_pkg::zoom_start(zx, {1'b0, cx_reg});
        sx1 = slte_pkg::zoom_start(zx, {1'b0, cx_reg} + 4'd1);
        sy0 = slte_pkg::zoom_start(zy, {1'b0, cy_reg});
        sy1 = slte_pkg::zoom_start(zy, {1'b0, cy_reg} + 4'd1);
        c = (code + 13'(slte_pkg::cell_x_add(ix)) + 13'(slte_pkg::cell_y_add(iy)))
            & mask_reg;
        xw = {e_reg[6][0], e_reg[7]} + {1'b0, sx0};
        px = {2'b00, xw} - 11'(slte_pkg::X_BIAS) - {{2{xoff_reg[8]}}, xoff_reg};
        py = 11'd256 - {2'b00, e_reg[4][0], e_reg[5]} + {3'b000, sy0}
             - {{2{yoff_reg[8]}}, yoff_reg} - 11'd16;
    end

    logic [6:0] key;
    assign key = rdata[6:0] ^ {7{ftb_reg}};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            m_axis_tvalid <= 1'b0;
            xoff_reg      <= '0;
            yoff_reg      <= '0;
            mask_reg      <= 13'h1fff;
            ftb_reg       <= 1'b0;
            chk_vld_reg   <= 1'b0;
            found_reg     <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    slte_pkg::REG_X_OFFSET:  xoff_reg <= cfg_data[8:0];
                    slte_pkg::REG_Y_OFFSET:  yoff_reg <= cfg_data[8:0];
                    slte_pkg::REG_CODE_MASK: mask_reg <= cfg_data;
                    slte_pkg::REG_FTB:       ftb_reg  <= cfg_data[0];
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
            case (state_reg)
                ST_IDLE: begin
                    if (s_acc) begin
                        slot_reg <= s_axis_tdata[26:20];
                        if (cmd == slte_pkg::CMD_READ) state_reg <= ST_READ;
                        else if (cmd == slte_pkg::CMD_RENDER) begin
                            state_reg   <= ST_SCAN;
                            scan_reg    <= '0;
                            chk_vld_reg <= 1'b0;
                            found_reg   <= 1'b0;
                        end
                    end
                end
                ST_READ: begin
                    m_axis_tdata  <= {56'd0, rdata};
                    m_axis_tlast  <= 1'b1;
                    m_axis_tvalid <= 1'b1;
                    state_reg     <= ST_IDLE;
                end
                ST_SCAN: begin
                    chk_reg     <= scan_reg;
                    chk_vld_reg <= (scan_reg != (SW+1)'(SPRITE_COUNT));
                    if (scan_reg != (SW+1)'(SPRITE_COUNT)) scan_reg <= scan_reg + 1'b1;
                    if (chk_vld_reg && rdata[7] && key == slot_reg) begin
                        found_reg <= 1'b1;
                        hit_reg   <= chk_reg[SW-1:0];
                    end
                    if (chk_vld_reg && chk_reg == (SW+1)'(SPRITE_COUNT - 1)) begin
                        chk_vld_reg <= 1'b0;
                        fcnt_reg    <= '0;
                        if (found_reg || (rdata[7] && key == slot_reg))
                            state_reg <= ST_FETCH;
                        else state_reg <= ST_IDLE;
                    end
                end
                ST_FETCH: begin
                    fcnt_reg <= fcnt_reg + 1'b1;
                    // the byte on rdata belongs to the address issued in the cycle before
                    if (fcnt_reg != 4'd0) e_reg[fcnt_reg[2:0] - 3'd1] <= rdata;
                    if (fcnt_reg == 4'd8) begin
                        cx_reg    <= '0;
                        cy_reg    <= '0;
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (!m_axis_tvalid || m_axis_tready) begin
                        m_axis_tdata <= {5'(sy1 - sy0), 5'(sx1 - sx0), fy, fx, py, px,
                                         e_reg[3][7], e_reg[3], c, 8'd0};
                        m_axis_tvalid <= 1'b1;
                        m_axis_tlast  <= 1'b0;
                        if ({1'b0, cx_reg} == w - 4'd1) begin
                            cx_reg <= '0;
                            if ({1'b0, cy_reg} == h - 4'd1) begin
                                m_axis_tlast <= 1'b1;
                                state_reg    <= ST_IDLE;
                            end else cy_reg <= cy_reg + 1'b1;
                        end else cx_reg <= cx_reg + 1'b1;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    a_no_accept_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        busy |-> !s_axis_tready) else $error("accept during ram clear");
    a_emit_from_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_axis_tvalid) |-> ($past(state_reg) == ST_EMIT || $past(state_reg) == ST_READ))
        else $error("result without work");
    a_hold_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_axis_tready) else $error("accept while busy");
endmodule
